@@ rtl/core/mvm_pkg.sv @@
// mvm_pkg: shared constants, codes, types and helpers for the matrix-vector multiplier
// depends on nothing; used by every module of the block except mvm_ram
package mvm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int DIM_W     = 4;
  localparam int OPND_W    = 16;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int RES_W     = 32;
  localparam int ACC_W     = PROD_W + IDX_W + 1;
  localparam int RIDX_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;

  // item kinds carried in tuser
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VEC    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCALAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 2'd2;

  localparam logic [DIM_W-1:0] ROWS_RST = 4'd2;
  localparam logic [DIM_W-1:0] COLS_RST = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  // one multiply-accumulate term issued by the sequencer
  typedef struct packed {
    logic              valid;
    logic              first;   // clears the accumulator
    logic              emit;    // closes a result
    logic              last;    // final result of the run
    logic              scal;    // second operand is the scalar
    logic [RIDX_W-1:0] idx;
  } issue_t;

  typedef struct packed {
    logic busy;      // terms still in the pipeline
    logic out_full;  // output register holds an untaken beat
  } status_t;

  // zero counts as one, anything above MAX_DIM counts as MAX_DIM
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = r;
    end
    return d;
  endfunction

endpackage

@@ rtl/core/matrix_vector_multiply.sv @@
// matrix_vector_multiply: top level of the fixed-point matrix-vector multiplier
// depends on mvm_pkg, mvm_ram, mvm_seq and mvm_mac
//
// Holds an up to 8x8 matrix of signed Q8.8 elements and an 8-entry vector in two
// synchronous RAMs. A load beat (tuser 0) writes one matrix element, a vector beat
// (tuser 1) writes one vector element. A vector beat with tlast set whose position
// plus one equals the vector length in use starts a product: matrix times column
// vector (orientation 0) or row vector times matrix (orientation 1). A scalar beat
// (tuser 2) emits every matrix element in use times the scalar, row-major. Results
// are Q16.16, saturated and flagged in tuser, with tlast on the final beat of the
// run. One multiplier walks the stored elements one term per cycle within a result,
// and one result is in flight at a time: its terms pass through the RAM read,
// multiply and accumulate stages ahead of the output register, and a result also
// waits while the output register still holds an untaken beat. The input is
// stalled while a run is in progress; it reopens in the cycle after the last
// result reaches the output register. Configuration must be written only while
// idle; the block itself does not enforce this.
module matrix_vector_multiply (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_index, col_index, vec_index, operand_value
  input  logic [1:0]  in_tuser,   // mode
  input  logic        in_tlast,   // last_element
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value, result_index
  output logic [0:0]  out_tuser,  // saturated
  output logic        out_tlast,  // last_result
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,  // 0 row_count, 1 col_count, 2 orientation
  input  logic [3:0]  cfg_data
);

  logic                              mat_we, vec_we;
  logic [mvm_pkg::MAT_AW-1:0]        mat_waddr, mat_raddr;
  logic [mvm_pkg::IDX_W-1:0]         vec_waddr, vec_raddr;
  logic [mvm_pkg::OPND_W-1:0]        mat_wdata, vec_wdata, mat_rdata, vec_rdata, scalar;
  mvm_pkg::issue_t                   issue;
  mvm_pkg::status_t                  status;
  logic [mvm_pkg::RES_W-1:0]         res_value;
  logic [mvm_pkg::RIDX_W-1:0]        res_index;
  logic                              res_sat, res_last;

  // decode, config registers and the term sequencer
  mvm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .mat_we     (mat_we),
    .mat_waddr  (mat_waddr),
    .mat_wdata  (mat_wdata),
    .mat_raddr  (mat_raddr),
    .vec_we     (vec_we),
    .vec_waddr  (vec_waddr),
    .vec_wdata  (vec_wdata),
    .vec_raddr  (vec_raddr),
    .scalar     (scalar),
    .issue      (issue),
    .status     (status)
  );

  // matrix store, row-major
  mvm_ram #(
    .WIDTH (mvm_pkg::OPND_W),
    .DEPTH (mvm_pkg::MAT_DEPTH)
  ) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  // vector store
  mvm_ram #(
    .WIDTH (mvm_pkg::OPND_W),
    .DEPTH (mvm_pkg::MAX_DIM)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  // multiply-accumulate pipeline and output register
  mvm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .mat_rdata  (mat_rdata),
    .vec_rdata  (vec_rdata),
    .scalar     (scalar),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_value  (res_value),
    .res_index  (res_index),
    .res_sat    (res_sat),
    .res_last   (res_last)
  );

  // pack the result beat, zero fill to whole bytes
  assign out_tdata = {2'b00, res_index, res_value};
  assign out_tuser = res_sat;
  assign out_tlast = res_last;

endmodule

@@ rtl/core/mvm_ram.sv @@
// mvm_ram: generic single-write, single-read synchronous RAM with registered read
// no dependencies
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mvm_seq.sv @@
// mvm_seq: input decode, configuration registers and the product sequencer
// depends on mvm_pkg; drives the two RAMs and the mac pipeline
module mvm_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,
  input  logic [mvm_pkg::MODE_W-1:0]   in_tuser,
  input  logic                         in_tlast,
  input  logic                         cfg_we,
  input  logic [mvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvm_pkg::DIM_W-1:0]    cfg_data,
  input  logic                         out_tready,
  output logic                         mat_we,
  output logic [mvm_pkg::MAT_AW-1:0]   mat_waddr,
  output logic [mvm_pkg::OPND_W-1:0]   mat_wdata,
  output logic [mvm_pkg::MAT_AW-1:0]   mat_raddr,
  output logic                         vec_we,
  output logic [mvm_pkg::IDX_W-1:0]    vec_waddr,
  output logic [mvm_pkg::OPND_W-1:0]   vec_wdata,
  output logic [mvm_pkg::IDX_W-1:0]    vec_raddr,
  output logic [mvm_pkg::OPND_W-1:0]   scalar,
  output mvm_pkg::issue_t              issue,
  input  mvm_pkg::status_t             status
);

  mvm_pkg::state_t state_r, state_nxt;
  logic [mvm_pkg::DIM_W-1:0]  rows_r, cols_r;
  logic                       orient_r;
  logic [mvm_pkg::IDX_W-1:0]  o_r, o_nxt, k_r, k_nxt;
  logic [mvm_pkg::DIM_W-1:0]  outs_r, outs_nxt, len_r, len_nxt;
  logic                       scal_r, scal_nxt;
  logic                       lastrun_r, lastrun_nxt;
  logic [mvm_pkg::RIDX_W-1:0] ridx_r, ridx_nxt;
  logic [mvm_pkg::OPND_W-1:0] scalar_r, scalar_nxt;

  logic [mvm_pkg::IDX_W-1:0]  f_row, f_col, f_vec;
  logic [mvm_pkg::OPND_W-1:0] f_opv;
  logic [mvm_pkg::DIM_W-1:0]  rows, cols, need, outs;
  logic                       in_fire, k_end, o_end;

  assign f_row = in_tdata[2:0];
  assign f_col = in_tdata[5:3];
  assign f_vec = in_tdata[8:6];
  assign f_opv = in_tdata[24:9];

  assign rows = mvm_pkg::dim_clamp(rows_r);
  assign cols = mvm_pkg::dim_clamp(cols_r);
  assign need = orient_r ? rows : cols;
  assign outs = orient_r ? cols : rows;

  assign in_tready = (state_r == mvm_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign mat_waddr = {f_row, f_col};
  assign mat_wdata = f_opv;
  assign vec_waddr = f_vec;
  assign vec_wdata = f_opv;
  assign mat_raddr = (scal_r || !orient_r) ? {o_r, k_r} : {k_r, o_r};
  assign vec_raddr = k_r;
  assign scalar    = scalar_r;

  assign k_end = ({1'b0, k_r} == (len_r - mvm_pkg::DIM_W'(1)));
  assign o_end = ({1'b0, o_r} == (outs_r - mvm_pkg::DIM_W'(1)));

  always_comb begin
    state_nxt   = state_r;
    o_nxt       = o_r;
    k_nxt       = k_r;
    outs_nxt    = outs_r;
    len_nxt     = len_r;
    scal_nxt    = scal_r;
    lastrun_nxt = lastrun_r;
    ridx_nxt    = ridx_r;
    scalar_nxt  = scalar_r;
    mat_we      = 1'b0;
    vec_we      = 1'b0;
    issue       = '0;
    unique case (state_r)
      mvm_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_tuser)
            mvm_pkg::MODE_LOAD: begin
              mat_we = 1'b1;
            end
            mvm_pkg::MODE_VEC: begin
              vec_we = 1'b1;
              if (in_tlast && (({1'b0, f_vec} + mvm_pkg::DIM_W'(1)) == need)) begin
                state_nxt   = mvm_pkg::ST_WAIT;
                o_nxt       = '0;
                k_nxt       = '0;
                outs_nxt    = outs;
                len_nxt     = need;
                scal_nxt    = 1'b0;
                lastrun_nxt = 1'b0;
                ridx_nxt    = '0;
              end
            end
            mvm_pkg::MODE_SCALAR: begin
              state_nxt   = mvm_pkg::ST_WAIT;
              o_nxt       = '0;
              k_nxt       = '0;
              outs_nxt    = rows;
              len_nxt     = cols;
              scal_nxt    = 1'b1;
              lastrun_nxt = 1'b0;
              ridx_nxt    = '0;
              scalar_nxt  = f_opv;
            end
            default: ;
          endcase
        end
      end
      mvm_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        issue.first = scal_r || (k_r == '0);
        issue.emit  = scal_r || k_end;
        issue.last  = o_end && k_end;
        issue.scal  = scal_r;
        issue.idx   = scal_r ? ridx_r : mvm_pkg::RIDX_W'(o_r);
        if (k_end) begin
          k_nxt = '0;
          o_nxt = o_r + mvm_pkg::IDX_W'(1);
        end else begin
          k_nxt = k_r + mvm_pkg::IDX_W'(1);
        end
        if (scal_r) begin
          ridx_nxt = ridx_r + mvm_pkg::RIDX_W'(1);
        end
        if (issue.emit) begin
          state_nxt   = mvm_pkg::ST_WAIT;
          lastrun_nxt = issue.last;
        end
      end
      mvm_pkg::ST_WAIT: begin
        // one result in flight at a time, and only into a free output register
        if (!status.busy) begin
          if (lastrun_r) begin
            state_nxt = mvm_pkg::ST_IDLE;
          end else if (!status.out_full || out_tready) begin
            state_nxt = mvm_pkg::ST_RUN;
          end
        end
      end
      default: state_nxt = mvm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mvm_pkg::ST_IDLE;
      rows_r    <= mvm_pkg::ROWS_RST;
      cols_r    <= mvm_pkg::COLS_RST;
      orient_r  <= 1'b0;
      lastrun_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lastrun_r <= lastrun_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mvm_pkg::CFG_ROWS:   rows_r   <= cfg_data;
          mvm_pkg::CFG_COLS:   cols_r   <= cfg_data;
          mvm_pkg::CFG_ORIENT: orient_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    o_r      <= o_nxt;
    k_r      <= k_nxt;
    outs_r   <= outs_nxt;
    len_r    <= len_nxt;
    scal_r   <= scal_nxt;
    ridx_r   <= ridx_nxt;
    scalar_r <= scalar_nxt;
  end

endmodule

@@ rtl/core/mvm_mac.sv @@
// mvm_mac: multiply, accumulate, saturate and the output register
// depends on mvm_pkg; fed by mvm_seq and the two RAM read ports
module mvm_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mvm_pkg::issue_t             issue,
  input  logic [mvm_pkg::OPND_W-1:0]  mat_rdata,
  input  logic [mvm_pkg::OPND_W-1:0]  vec_rdata,
  input  logic [mvm_pkg::OPND_W-1:0]  scalar,
  output mvm_pkg::status_t            status,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mvm_pkg::RES_W-1:0]   res_value,
  output logic [mvm_pkg::RIDX_W-1:0]  res_index,
  output logic                        res_sat,
  output logic                        res_last
);

  mvm_pkg::issue_t s1_r, s2_r, s3_r;
  logic [mvm_pkg::OPND_W-1:0]        opb;
  logic signed [mvm_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic [mvm_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic                              over;
  logic                              out_valid_r;

  assign opb      = s1_r.scal ? scalar : vec_rdata;
  assign prod_nxt = $signed(mat_rdata) * $signed(opb);
  assign acc_nxt  = (s2_r.first ? '0 : acc_r)
                  + {{(mvm_pkg::ACC_W - mvm_pkg::PROD_W){prod_r[mvm_pkg::PROD_W-1]}}, prod_r};
  // out of range when the bits above the result's sign differ from it
  assign over = (acc_r[mvm_pkg::ACC_W-1:mvm_pkg::RES_W-1]
                 != {(mvm_pkg::ACC_W - mvm_pkg::RES_W + 1){acc_r[mvm_pkg::ACC_W-1]}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      s3_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_r <= issue;
      s2_r <= s1_r;
      s3_r <= s2_r;
      if (s3_r.valid && s3_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (s2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (s3_r.valid && s3_r.emit) begin
      res_index <= s3_r.idx;
      res_last  <= s3_r.last;
      res_sat   <= over;
      if (!over) begin
        res_value <= acc_r[mvm_pkg::RES_W-1:0];
      end else if (acc_r[mvm_pkg::ACC_W-1]) begin
        res_value <= {1'b1, {(mvm_pkg::RES_W-1){1'b0}}};
      end else begin
        res_value <= {1'b0, {(mvm_pkg::RES_W-1){1'b1}}};
      end
    end
  end

  assign out_tvalid      = out_valid_r;
  assign status.busy     = s1_r.valid || s2_r.valid || s3_r.valid;
  assign status.out_full = out_valid_r;

endmodule

@@ rtl/core/mvm_checker.sv @@
// mvm_props: port-level assertions for matrix_vector_multiply, bound to the top level
// depends on mvm_pkg
module mvm_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [3:0]  cfg_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // a scalar beat always starts a run, so the input closes behind it
  a_scalar_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mvm_pkg::MODE_SCALAR) |=> !in_tready)
    else $error("input still open after a scalar beat");

  // matrix loads never start a run
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mvm_pkg::MODE_LOAD) |=> in_tready)
    else $error("input closed after a matrix load");

  // a clipped value sits exactly at a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[31:0] == 32'h7FFF_FFFF) || (out_tdata[31:0] == 32'h8000_0000))
    else $error("saturated flag on a value that is not a bound");

  // a new result only comes out of a run, never while the input is open
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while idle");

endmodule

bind matrix_vector_multiply mvm_props u_mvm_props (.*);
